>>> sv/stq_pkg.sv
// shared types and constants of the sorted deadline timer queue
// no dependencies; imported by every module of the block
`default_nettype none

package stq_pkg;

  // queue depth and scheduler tick divider (divider is a power of two)
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned TICK_DIV   = 32;
  localparam int unsigned TICK_SHIFT = $clog2(TICK_DIV);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  // field widths
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned DELAY_W = 40;
  localparam int unsigned HND_W   = 16;
  localparam int unsigned FREQ_W  = 32;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;

  // input kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] RK_EXPIRED = 2'd0;
  localparam logic [1:0] RK_REARM   = 2'd1;
  localparam logic [1:0] RK_ADDED   = 2'd2;
  localparam logic [1:0] RK_FULL    = 2'd3;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] dl;
    logic [HND_W-1:0]  handle;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/stq_cell.sv
// one queue slot: holds a deadline and handle, compares against a new
// deadline, and shifts right on insert or left on pop; uses stq_pkg
`default_nettype none

module stq_cell
  import stq_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic              occ,
  input  wire logic              left_go,
  input  wire logic [TIME_W-1:0] left_dl,
  input  wire logic [HND_W-1:0]  left_handle,
  input  wire logic [TIME_W-1:0] right_dl,
  input  wire logic [HND_W-1:0]  right_handle,
  output logic                   go,
  output logic [TIME_W-1:0]      dl,
  output logic [HND_W-1:0]       handle
);

  logic [TIME_W-1:0] dl_r, dl_nxt;
  logic [HND_W-1:0]  handle_r, handle_nxt;

  // new word lands here or further left when this slot is free or later
  assign go = !occ || (ctrl.dl < dl_r);

  // slot update
  always_comb begin
    dl_nxt     = dl_r;
    handle_nxt = handle_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (go) begin
          if (left_go) begin
            dl_nxt     = left_dl;
            handle_nxt = left_handle;
          end else begin
            dl_nxt     = ctrl.dl;
            handle_nxt = ctrl.handle;
          end
        end
      end
      CELL_SHIFT: begin
        dl_nxt     = right_dl;
        handle_nxt = right_handle;
      end
      default: begin
        dl_nxt     = dl_r;
        handle_nxt = handle_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dl_r     <= dl_nxt;
    handle_r <= handle_nxt;
  end

  assign dl     = dl_r;
  assign handle = handle_r;

endmodule

`default_nettype wire

>>> sv/sorted_deadline_timer_queue_core.sv
// An accepted item goes to S_CALC, where the deadline or rearm value is
// summed, then to S_ADD or S_POP. An add gives its one word from S_ADD. A
// tick gives one expired word per cycle in S_POP while the output is free,
// then S_REARM gives the rearm word. One item at a time: in_ready only in S_IDLE.
// Reset (synchronous, rst_n low): queue empty, frequency 10000000, no output.
// top level: sequencer, entry count, output register and the row of cells
// depends on stq_pkg and stq_cell
`default_nettype none

module sorted_deadline_timer_queue_core
  import stq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [TIME_W-1:0]  in_now,
  input  wire logic [DELAY_W-1:0] in_delay_ticks,
  input  wire logic [HND_W-1:0]   in_handle,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_result_kind,
  output logic [HND_W-1:0]        out_expired_handle,
  output logic [TIME_W-1:0]       out_compare_value,
  output logic                    out_resched_req,
  output logic                    out_last,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FREQ_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ADD,
    S_POP,
    S_REARM
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [FREQ_W-1:0]  freq_r;
  logic               kind_r;
  logic [TIME_W-1:0]  now_r;
  logic [DELAY_W-1:0] delay_r;
  logic [HND_W-1:0]   hnd_r;
  logic [TIME_W-1:0]  sum_r, sum_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         rk_r, rk_nxt;
  logic [HND_W-1:0]   exp_r, exp_nxt;
  logic [TIME_W-1:0]  cmp_r, cmp_nxt;
  logic               resched_r, resched_nxt;
  logic               last_r, last_nxt;

  cell_ctrl_t         ctrl;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] cell_go;
  logic [CAPACITY-1:0] left_go;
  logic [TIME_W-1:0]  cell_dl [CAPACITY];
  logic [HND_W-1:0]   cell_hd [CAPACITY];
  logic [TIME_W-1:0]  left_dl [CAPACITY];
  logic [HND_W-1:0]   left_hd [CAPACITY];
  logic [TIME_W-1:0]  right_dl [CAPACITY];
  logic [HND_W-1:0]   right_hd [CAPACITY];

  logic out_free, full, pop_hit, accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign pop_hit   = occ[0] && (cell_dl[0] <= now_r);

  // row of cells with neighbor links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count_r > CNT_W'(i));
    if (i == 0) begin : g_first
      assign left_go[i] = 1'b0;
      assign left_dl[i] = ctrl.dl;
      assign left_hd[i] = ctrl.handle;
    end else begin : g_inner
      assign left_go[i] = cell_go[i-1];
      assign left_dl[i] = cell_dl[i-1];
      assign left_hd[i] = cell_hd[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_dl[i] = cell_dl[i];
      assign right_hd[i] = cell_hd[i];
    end else begin : g_mid
      assign right_dl[i] = cell_dl[i+1];
      assign right_hd[i] = cell_hd[i+1];
    end
    stq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occ          (occ[i]),
      .left_go      (left_go[i]),
      .left_dl      (left_dl[i]),
      .left_handle  (left_hd[i]),
      .right_dl     (right_dl[i]),
      .right_handle (right_hd[i]),
      .go           (cell_go[i]),
      .dl           (cell_dl[i]),
      .handle       (cell_hd[i])
    );
  end

  // sequencer: next state, cell operation and output word
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    ctrl.op       = CELL_HOLD;
    ctrl.dl       = sum_r;
    ctrl.handle   = hnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rk_nxt        = rk_r;
    exp_nxt       = exp_r;
    cmp_nxt       = cmp_r;
    resched_nxt   = resched_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CALC;
      end
      S_CALC: begin
        // deadline for an add, tick-based rearm value for a tick
        if (kind_r == KIND_ADD) begin
          sum_nxt   = now_r + TIME_W'(delay_r);
          state_nxt = S_ADD;
        end else begin
          sum_nxt   = now_r + TIME_W'(freq_r >> TICK_SHIFT);
          state_nxt = S_POP;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          exp_nxt       = '0;
          resched_nxt   = 1'b0;
          last_nxt      = 1'b1;
          cmp_nxt       = '0;
          if (full) begin
            rk_nxt = RK_FULL;
          end else begin
            ctrl.op   = CELL_INSERT;
            count_nxt = count_r + 1'b1;
            if (cell_go[0]) begin
              rk_nxt  = RK_REARM;
              cmp_nxt = sum_r;
            end else begin
              rk_nxt = RK_ADDED;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        // one expired head per cycle while the output is free
        if (!pop_hit) begin
          state_nxt = S_REARM;
        end else if (out_free) begin
          ctrl.op       = CELL_SHIFT;
          count_nxt     = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          rk_nxt        = RK_EXPIRED;
          exp_nxt       = cell_hd[0];
          cmp_nxt       = '0;
          resched_nxt   = 1'b0;
          last_nxt      = 1'b0;
        end
      end
      S_REARM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          rk_nxt        = RK_REARM;
          exp_nxt       = '0;
          cmp_nxt       = (occ[0] && (cell_dl[0] < sum_r)) ? cell_dl[0] : sum_r;
          resched_nxt   = 1'b1;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      freq_r      <= FREQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) freq_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      now_r   <= in_now;
      delay_r <= in_delay_ticks;
      hnd_r   <= in_handle;
    end
    sum_r     <= sum_nxt;
    rk_r      <= rk_nxt;
    exp_r     <= exp_nxt;
    cmp_r     <= cmp_nxt;
    resched_r <= resched_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = rk_r;
  assign out_expired_handle = exp_r;
  assign out_compare_value  = cmp_r;
  assign out_resched_req    = resched_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

>>> sv/stq_checker.sv
// port-level checks of the timer queue top level, with its bind
// depends on stq_pkg and sorted_deadline_timer_queue_core
`default_nettype none

module stq_checker
  import stq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_result_kind,
  input wire logic [HND_W-1:0]   out_expired_handle,
  input wire logic [TIME_W-1:0]  out_compare_value,
  input wire logic               out_resched_req,
  input wire logic               out_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_expired_handle) && $stable(out_compare_value) && $stable(out_last))
    else $error("stalled output word changed");

  // expired handles never close an item, every other kind does
  a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_EXPIRED) |-> !out_last)
    else $error("expired word marked last");

  a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != RK_EXPIRED) |-> out_last)
    else $error("closing word not marked last");

  // reschedule request only rides on a rearm word
  a_resched_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_resched_req |-> (out_result_kind == RK_REARM))
    else $error("reschedule request on non-rearm word");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind sorted_deadline_timer_queue_core stq_checker u_stq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_expired_handle (out_expired_handle),
  .out_compare_value  (out_compare_value),
  .out_resched_req    (out_resched_req),
  .out_last           (out_last)
);

`default_nettype wire

>>> test/tb_sorted_deadline_timer_queue_core.sv
// testbench of the sorted deadline timer queue: directed and random add and tick words,
// a scoreboard that predicts every result word and checks the output channel against it
// depends on stq_pkg and sorted_deadline_timer_queue_core
`default_nettype none

module tb_sorted_deadline_timer_queue_core
  import stq_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // one result word as the block should give it
  typedef struct packed {
    logic [1:0]        kind;
    logic [HND_W-1:0]  handle;
    logic [TIME_W-1:0] cmp_value;
    logic              resched;
    logic              is_last;
  } timer_word_t;

  // timer queue predictor and store of expected result words
  class deadline_scoreboard;
    logic [FREQ_W-1:0] freq;
    logic [TIME_W-1:0] pending_deadline [CAPACITY];
    logic [HND_W-1:0]  pending_handle [CAPACITY];
    int                pending_count;
    timer_word_t       expected_words [$];
    int unsigned       errors;

    function new();
      freq          = FREQ_RESET;
      pending_count = 0;
      errors        = 0;
    endfunction

    function void push_word(logic [1:0] kind, logic [HND_W-1:0] handle,
                            logic [TIME_W-1:0] cmp_value, logic resched, logic is_last);
      timer_word_t w;
      w.kind      = kind;
      w.handle    = handle;
      w.cmp_value = cmp_value;
      w.resched   = resched;
      w.is_last   = is_last;
      expected_words.push_back(w);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // apply one accepted input word to the queue and queue up its results
    function void note_item(logic kind, logic [TIME_W-1:0] now,
                            logic [DELAY_W-1:0] delay, logic [HND_W-1:0] handle);
      logic [TIME_W-1:0] dl;
      logic [TIME_W-1:0] rearm;
      int pos;
      int popped;
      int i;
      if (kind == KIND_ADD) begin
        if (pending_count >= CAPACITY) begin
          push_word(RK_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          dl  = now + TIME_W'(delay);
          pos = 0;
          // equal deadlines go behind the ones already queued
          while (pos < pending_count && !(dl < pending_deadline[pos])) pos++;
          for (i = pending_count; i > pos; i--) begin
            pending_deadline[i] = pending_deadline[i-1];
            pending_handle[i]   = pending_handle[i-1];
          end
          pending_deadline[pos] = dl;
          pending_handle[pos]   = handle;
          pending_count++;
          if (pos == 0) push_word(RK_REARM, '0, dl, 1'b0, 1'b1);
          else          push_word(RK_ADDED, '0, '0, 1'b0, 1'b1);
        end
      end else begin
        // pop every expired head entry
        popped = 0;
        while (popped < pending_count && pending_deadline[popped] <= now) begin
          push_word(RK_EXPIRED, pending_handle[popped], '0, 1'b0, 1'b0);
          popped++;
        end
        for (i = 0; i + popped < pending_count; i++) begin
          pending_deadline[i] = pending_deadline[i+popped];
          pending_handle[i]   = pending_handle[i+popped];
        end
        pending_count -= popped;
        // rearm at the next scheduler tick or the new head, whichever comes first
        rearm = now + TIME_W'(freq / TICK_DIV);
        if (pending_count > 0 && pending_deadline[0] < rearm) rearm = pending_deadline[0];
        push_word(RK_REARM, '0, rearm, 1'b1, 1'b1);
      end
    endfunction

    // compare one output word with the oldest expected one
    task check_word(timer_word_t got);
      timer_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, kind %0d", got.kind));
      end else begin
        want = expected_words.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
        if (got.handle !== want.handle)
          report_mismatch($sformatf("expired_handle %h, expected %h",
                                    got.handle, want.handle));
        if (got.cmp_value !== want.cmp_value)
          report_mismatch($sformatf("compare_value %h, expected %h",
                                    got.cmp_value, want.cmp_value));
        if (got.resched !== want.resched)
          report_mismatch($sformatf("resched_req %b, expected %b",
                                    got.resched, want.resched));
        if (got.is_last !== want.is_last)
          report_mismatch($sformatf("last %b, expected %b", got.is_last, want.is_last));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KIND_ADD;
  logic [TIME_W-1:0]  in_now = '0;
  logic [DELAY_W-1:0] in_delay_ticks = '0;
  logic [HND_W-1:0]   in_handle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_result_kind;
  logic [HND_W-1:0]   out_expired_handle;
  logic [TIME_W-1:0]  out_compare_value;
  logic               out_resched_req;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FREQ_W-1:0]  cfg_wdata = '0;

  deadline_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        tx_idle_pct = 33;
  int unsigned        rx_idle_pct = 80;
  logic [TIME_W-1:0]  tnow;

  sorted_deadline_timer_queue_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_now             (in_now),
    .in_delay_ticks     (in_delay_ticks),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_expired_handle (out_expired_handle),
    .out_compare_value  (out_compare_value),
    .out_resched_req    (out_resched_req),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, check every accepted result word
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_result_kind, out_expired_handle, out_compare_value,
                     out_resched_req, out_last});
  end

  // send one input word, idling first at the sender's rate
  task automatic send_word(input logic kind, input logic [TIME_W-1:0] now,
                           input logic [DELAY_W-1:0] delay, input logic [HND_W-1:0] handle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_now         <= now;
    in_delay_ticks <= delay;
    in_handle      <= handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(kind, now, delay, handle);
  endtask

  // hold off the sender until every expected word has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_timebase(input logic [FREQ_W-1:0] freq);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_wdata <= freq;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.freq = freq;
  endtask

  // mostly a running time base with short delays, some noise with arbitrary values
  task automatic random_item();
    logic               kind;
    logic [TIME_W-1:0]  now;
    logic [DELAY_W-1:0] delay;
    int unsigned        r;
    r     = $urandom_range(99);
    delay = DELAY_W'($urandom_range(400));
    if (r < 8) begin
      now   = {$urandom, $urandom};
      kind  = 1'($urandom);
      delay = DELAY_W'({$urandom, $urandom});
    end else begin
      tnow = tnow + TIME_W'($urandom_range(150));
      now  = tnow;
      if (r < 14)      delay = DELAY_W'({$urandom, $urandom});
      else if (r < 20) delay = '0;
      kind = ($urandom_range(99) < (sb.pending_count >= 12 ? 45 : 62)) ? KIND_ADD : KIND_TICK;
    end
    send_word(kind, now, delay, HND_W'($urandom));
    if ($urandom_range(99) < 2) wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: head insertion, equal deadlines, full delay, wrapping deadline
    send_word(KIND_ADD, 64'd100, '0, 16'h0000);
    send_word(KIND_ADD, 64'd100, '0, 16'hffff);
    send_word(KIND_ADD, 64'd50, 40'd10, 16'h0001);
    send_word(KIND_ADD, 64'd0, '1, 16'h0002);
    send_word(KIND_ADD, 64'hffff_ffff_ffff_fff0, 40'd32, 16'h0003);
    send_word(KIND_TICK, 64'd100, '0, '0);
    // fill the queue, one add past full, then drain all at once
    repeat (15) send_word(KIND_ADD, 64'd1000, DELAY_W'($urandom_range(7)), HND_W'($urandom));
    send_word(KIND_ADD, 64'd1000, 40'd5, 16'h5a5a);
    send_word(KIND_TICK, '1, '0, '0);
    // zero tick frequency on an empty queue
    set_timebase('0);
    send_word(KIND_TICK, 64'd5, '0, '0);

    // random phases with different idling and frequencies
    set_timebase('1);
    tnow = '0;
    repeat (120) random_item();

    set_timebase(32'd1);
    tx_idle_pct = 80;
    rx_idle_pct = 33;
    tnow = 64'hffff_ffff_ffff_f000;
    repeat (120) random_item();

    set_timebase($urandom);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tnow = {$urandom, 32'h0};
    repeat (120) random_item();

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
